FILE: hw/rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants of the softmax row unit
// Widths, the log2(e) multiplier and the 2^(-f/256) fraction table.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int RESULT_CAP      = 16;
  localparam int LEN_W           = 5;
  localparam int DATA_W          = 16;
  localparam int ACC_W           = 40;
  localparam int EXP_W           = 17;
  localparam int SUM_W           = 21;
  localparam int NUM_W           = 34;
  localparam int QUOT_W          = 17;
  localparam int MUL_A_W         = 25;
  localparam int MUL_B_W         = 18;
  localparam int MUL_P_W         = MUL_A_W + MUL_B_W;
  localparam int LOG2E_Q15       = 47274;
  localparam int EXP_LIMIT       = 4096;

  typedef logic [EXP_W-1:0] exp_tbl_t [256];

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [127:0] rem;
    logic [127:0] res;
    logic [127:0] b;
    rem = {64'd0, n};
    res = '0;
    b   = 128'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > rem) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res[63:0];
  endfunction

  function automatic exp_tbl_t build_exp_table();
    logic [63:0]  root [8];
    logic [127:0] acc;
    exp_tbl_t     tbl;
    root[7] = isqrt(64'd1 << 63);
    for (int b = 6; b >= 0; b--) root[b] = isqrt(root[b+1] << 32);
    for (int f = 0; f < 256; f++) begin
      acc = 128'd1 << 32;
      for (int b = 0; b < 8; b++) begin
        if (((f >> b) & 1) != 0) acc = (acc * {64'd0, root[b]} + (128'd1 << 31)) >> 32;
      end
      acc = (acc + 128'd32768) >> 16;
      tbl[f] = acc[EXP_W-1:0];
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TABLE = build_exp_table();

endpackage

FILE: hw/rtl/smx_in_if.sv
// ----------------------------------------------------------------------------
// smx_in_if: element request channel
// Valid/ready channel carrying one row element.
// ----------------------------------------------------------------------------
interface smx_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] value;
  logic        [15:0] prob;

  modport source (output valid, mode, value, prob, input ready);
  modport sink (input valid, mode, value, prob, output ready);
endinterface

FILE: hw/rtl/smx_out_if.sv
// ----------------------------------------------------------------------------
// smx_out_if: result request channel
// Valid/ready channel carrying one row result.
// ----------------------------------------------------------------------------
interface smx_out_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  index;
  logic        [15:0] probability;
  logic signed [15:0] gradient;
  logic               last;

  modport source (output valid, index, probability, gradient, last, input ready);
  modport sink (input valid, index, probability, gradient, last, output ready);
endinterface

FILE: hw/rtl/smx_mul.sv
// ----------------------------------------------------------------------------
// smx_mul: shared signed multiplier
// One registered 25x18 signed product per cycle.
// ----------------------------------------------------------------------------
module smx_mul
  import smx_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hw/rtl/smx_div.sv
// ----------------------------------------------------------------------------
// smx_div: restoring divider
// One quotient bit per cycle; the numerator is known to be below den * 2^17.
// ----------------------------------------------------------------------------
module smx_div
  import smx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [SUM_W-1:0]  den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic [SUM_W-1:0]  rem;
  logic [QUOT_W-1:0] low;
  logic [4:0]        cnt;
  logic              busy;
  logic [SUM_W:0]    trial;
  logic              take;

  assign trial = {rem, low[QUOT_W-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[NUM_W-1:QUOT_W];
      low  <= num[QUOT_W-1:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= take ? SUM_W'(trial - {1'b0, den}) : trial[SUM_W-1:0];
      low  <= {low[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], take};
    end
  end

endmodule

FILE: hw/rtl/softmax_row_unit.sv
// ----------------------------------------------------------------------------
// softmax_row_unit: softmax and softmax backward over one row
// Sequencer around a shared multiplier, a bit-serial divider and row stores.
// ----------------------------------------------------------------------------
// Elements of a row are taken one request at a time: a forward logit is
// stored, a backward gradient/probability pair is multiplied, then
// accumulated. When the row of L elements is complete the unit stops taking
// requests and emits L results in index order. Forward rows first run an
// exponent pass per element (store read, log2e multiply, table lookup and
// shift), then per result: read, divider start, 17 bit-serial divide steps,
// the done strobe and the output register. Backward rows take per result a
// read, two passes through the shared multiplier for the wide product, the
// sum and the output register. Each result sits in the output register
// until taken, and the next result waits for it.
// ----------------------------------------------------------------------------
module softmax_row_unit
  import smx_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  smx_in_if.sink           elem,
  smx_out_if.source        result
);

  localparam int DEPTH = (MAX_CLASSES < RESULT_CAP) ? MAX_CLASSES : RESULT_CAP;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_XRD   = 4'd2;
  localparam logic [3:0] S_XMUL  = 4'd3;
  localparam logic [3:0] S_XEXP  = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DSTRT = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BLO   = 4'd9;
  localparam logic [3:0] S_BHI   = 4'd10;
  localparam logic [3:0] S_BSUM  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  logic [3:0]               state;
  logic [LEN_W-1:0]         row_length;
  logic [LEN_W-1:0]         fill;
  logic [LEN_W-1:0]         pos;
  logic                     row_mode;
  logic signed [DATA_W-1:0] run_max;
  logic signed [ACC_W-1:0]  acc;

  logic [DATA_W-1:0] row_mem  [DEPTH];
  logic [DATA_W-1:0] prob_mem [DEPTH];
  logic [EXP_W-1:0]  exp_mem  [DEPTH];
  logic [DATA_W-1:0] rd_row;
  logic [DATA_W-1:0] rd_prob;
  logic [EXP_W-1:0]  rd_exp;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MUL_P_W-1:0] lo_prod;
  logic signed [16:0]        diff_hi;

  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  logic        out_valid;
  logic [3:0]  out_index;
  logic [15:0] out_prob;
  logic [15:0] out_grad;
  logic        out_last;

  // effective length and request bookkeeping
  logic [LEN_W-1:0]         eff_len;
  logic                     accept;
  logic                     restart;
  logic [LEN_W-1:0]         fill0;
  logic [LEN_W-1:0]         fill_inc;
  logic signed [DATA_W-1:0] max0;
  logic signed [ACC_W-1:0]  acc0;

  always_comb begin
    if (row_length == '0) eff_len = LEN_W'(1);
    else if (row_length > LEN_W'(DEPTH)) eff_len = LEN_W'(DEPTH);
    else eff_len = row_length;
  end

  assign elem.ready = (state == S_IDLE);
  assign accept     = elem.valid && elem.ready;
  assign restart    = ((fill != '0) && (elem.mode != row_mode)) || (fill >= eff_len);
  assign fill0      = restart ? '0 : fill;
  assign fill_inc   = fill0 + LEN_W'(1);
  assign max0       = restart ? MIN_VAL : run_max;
  assign acc0       = restart ? '0 : acc;

  // exponent from the registered log2e product
  logic [NUM_W-1:0] k_round;
  logic [18:0]      k;
  logic [EXP_W-1:0] t_val;
  logic [EXP_W:0]   t_shift;
  logic [EXP_W:0]   t_half;
  logic [EXP_W-1:0] e_val;
  logic [16:0]      m_val;

  assign m_val   = 17'({run_max[DATA_W-1], run_max} - {rd_row[DATA_W-1], rd_row});
  assign k_round = mul_p[NUM_W-1:0] + NUM_W'(16384);
  assign k       = k_round[33:15];
  assign t_val   = EXP_TABLE[k[7:0]];
  assign t_shift = {t_val, 1'b0} >> k[12:8];
  assign t_half  = (t_shift + (EXP_W+1)'(1)) >> 1;
  assign e_val   = (k > 19'(EXP_LIMIT)) ? '0 : t_half[EXP_W-1:0];

  // divider operands: e * 2^16 + sum / 2 over sum
  logic [NUM_W-1:0] div_num;
  logic [SUM_W-1:0] sum_val;
  logic [15:0]      q_sat;

  assign sum_val = acc[SUM_W-1:0];
  assign div_num = {1'b0, rd_exp, 16'd0} + NUM_W'(sum_val >> 1);
  assign q_sat   = (sum_val == '0) ? 16'd0 :
                   (div_quot[QUOT_W-1] ? 16'hFFFF : div_quot[15:0]);

  // backward: diff = g * 2^16 - s, product split across two multiplies
  logic signed [40:0] diff;
  logic signed [63:0] bwd_prod;
  logic signed [63:0] bwd_round;
  logic signed [31:0] bwd_r;
  logic [15:0]        grad_sat;

  assign diff      = {{9{rd_row[DATA_W-1]}}, rd_row, 16'd0} - 41'(acc);
  assign bwd_prod  = (64'(mul_p) <<< 24) + 64'(lo_prod);
  assign bwd_round = (bwd_prod + 64'sd2147483648) >>> 32;
  assign bwd_r     = bwd_round[31:0];
  always_comb begin
    if (bwd_r > 32'sd32767) grad_sat = 16'h7FFF;
    else if (bwd_r < -32'sd32768) grad_sat = 16'h8000;
    else grad_sat = bwd_r[15:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: begin
        mul_a = MUL_A_W'(elem.value);
        mul_b = {2'b00, elem.prob};
      end
      S_XMUL: begin
        mul_a = {8'd0, m_val};
        mul_b = MUL_B_W'(LOG2E_Q15);
      end
      S_BLO: begin
        mul_a = {1'b0, diff[23:0]};
        mul_b = {2'b00, rd_prob};
      end
      S_BHI: begin
        mul_a = MUL_A_W'(diff_hi);
        mul_b = {2'b00, rd_prob};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state == S_DSTRT);

  smx_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  smx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sum_val),
    .done  (div_done),
    .quot  (div_quot)
  );

  // stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[fill0[AW-1:0]]  <= elem.value;
      prob_mem[fill0[AW-1:0]] <= elem.prob;
    end
    if (state == S_XEXP) exp_mem[pos[AW-1:0]] <= e_val;
    rd_row  <= row_mem[pos[AW-1:0]];
    rd_prob <= prob_mem[pos[AW-1:0]];
    rd_exp  <= exp_mem[pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_BLO) diff_hi <= diff[40:24];
    if (state == S_BHI) lo_prod <= mul_p;
    if (state == S_DWAIT && div_done) begin
      out_index <= pos[3:0];
      out_prob  <= q_sat;
      out_grad  <= '0;
      out_last  <= (pos + LEN_W'(1)) == eff_len;
    end
    if (state == S_BSUM) begin
      out_index <= pos[3:0];
      out_prob  <= '0;
      out_grad  <= grad_sat;
      out_last  <= (pos + LEN_W'(1)) == eff_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_length <= LEN_W'(16);
      fill       <= '0;
      pos        <= '0;
      row_mode   <= 1'b0;
      run_max    <= MIN_VAL;
      acc        <= '0;
      out_valid  <= 1'b0;
    end else if (cfg_we) begin
      // drop any partial row
      row_length <= cfg_wdata;
      fill       <= '0;
      run_max    <= MIN_VAL;
      acc        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            row_mode <= elem.mode;
            fill     <= fill_inc;
            acc      <= acc0;
            pos      <= '0;
            if (elem.mode) begin
              run_max <= max0;
              state   <= S_ACC;
            end else begin
              run_max <= (elem.value > max0) ? elem.value : max0;
              if (fill_inc == eff_len) state <= S_XRD;
            end
          end
        end
        S_ACC: begin
          acc <= acc + ACC_W'(mul_p);
          state <= (fill == eff_len) ? S_BRD : S_IDLE;
        end
        S_XRD:  state <= S_XMUL;
        S_XMUL: state <= S_XEXP;
        S_XEXP: begin
          acc <= acc + ACC_W'(e_val);
          if (pos + LEN_W'(1) == eff_len) begin
            pos   <= '0;
            state <= S_DRD;
          end else begin
            pos   <= pos + LEN_W'(1);
            state <= S_XRD;
          end
        end
        S_DRD:   state <= S_DSTRT;
        S_DSTRT: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_BRD: state <= S_BLO;
        S_BLO: state <= S_BHI;
        S_BHI: state <= S_BSUM;
        S_BSUM: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              // row done: drop stored state
              fill    <= '0;
              run_max <= MIN_VAL;
              acc     <= '0;
              state   <= S_IDLE;
            end else begin
              pos   <= pos + LEN_W'(1);
              state <= row_mode ? S_BRD : S_DRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.index       = out_index;
  assign result.probability = out_prob;
  assign result.gradient    = out_grad;
  assign result.last        = out_last;

endmodule

FILE: sim/softmax_row_unit_tb.sv
// ----------------------------------------------------------------------------
// softmax_row_unit_tb: self-checking bench of the softmax row unit
// Drives forward and backward rows at several row lengths under random
// stalls on both channels and checks every result against a local model.
// ----------------------------------------------------------------------------
module softmax_row_unit_tb;
  import smx_pkg::*;

  typedef enum logic {MODE_FWD = 1'b0, MODE_BWD = 1'b1} elem_mode_e;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] value;
    logic        [15:0] prob;
  } elem_t;

  typedef struct packed {
    logic        [3:0]  index;
    logic        [15:0] probability;
    logic signed [15:0] gradient;
    logic               last;
  } res_t;

  localparam int CFG_ROW_LEN = 0;
  localparam int IDLE_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  smx_in_if  elem ();
  smx_out_if result ();

  softmax_row_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .elem(elem.sink), .result(result.source)
  );

  always #1 clk = ~clk;

  elem_t pending_elems[$];
  res_t  expected_results[$];
  int    fail_count = 0;
  int    src_idle_pct = 11;
  int    snk_idle_pct = 55;
  int    hold_off = 0;
  bit    src_pause = 1'b0;

  // shadow of the block's row state
  logic [15:0] row_vals [16];
  logic [15:0] row_probs [16];
  int          row_fill = 0;
  int          row_max = -32768;
  longint      grad_acc = 0;
  logic        cur_mode = MODE_FWD;
  int          len_reg = 16;

  function automatic longint exp_q16(int x, int mx);
    longint m, k, n, t;
    m = mx - x;
    k = (m * LOG2E_Q15 + 16384) >>> 15;
    if (k > EXP_LIMIT) return 0;
    n = k >> 8;
    t = EXP_TABLE[k & 255];
    if (n == 0) return t;
    return (t + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic int row_len_eff(int l);
    if (l == 0) return 1;
    if (l > 16) return 16;
    return l;
  endfunction

  task automatic clear_shadow();
    row_fill = 0;
    row_max = -32768;
    grad_acc = 0;
  endtask

  task automatic predict_row(elem_t e);
    int len, v;
    longint sum, ex, q, g, diff, prod, r;
    res_t rr;
    len = row_len_eff(len_reg);
    v = e.value;
    if (row_fill > 0 && e.mode != cur_mode) clear_shadow();
    cur_mode = e.mode;
    if (row_fill >= len) clear_shadow();
    row_vals[row_fill] = e.value;
    row_probs[row_fill] = e.prob;
    if (e.mode == MODE_FWD) begin
      if (v > row_max) row_max = v;
    end else begin
      grad_acc += longint'(v) * longint'(e.prob);
    end
    row_fill++;
    if (row_fill < len) return;
    sum = 0;
    if (e.mode == MODE_FWD)
      for (int i = 0; i < len; i++) sum += exp_q16($signed(row_vals[i]), row_max);
    for (int i = 0; i < len; i++) begin
      rr.index = i[3:0];
      rr.last = (i + 1 == len);
      if (e.mode == MODE_FWD) begin
        ex = exp_q16($signed(row_vals[i]), row_max);
        q = (sum != 0) ? (ex * 65536 + sum / 2) / sum : 0;
        if (q > 65535) q = 65535;
        rr.probability = q[15:0];
        rr.gradient = '0;
      end else begin
        g = $signed(row_vals[i]);
        diff = g * 65536 - grad_acc;
        prod = diff * longint'(row_probs[i]);
        r = (prod + (64'sd1 <<< 31)) >>> 32;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        rr.probability = '0;
        rr.gradient = r[15:0];
      end
      expected_results.push_back(rr);
    end
    clear_shadow();
  endtask

  // driver: offer the head of the pending queue, advance on acceptance
  always @(posedge clk) begin
    if (rst) begin
      elem.valid <= 1'b0;
    end else begin
      if (elem.valid && elem.ready) begin
        predict_row(pending_elems.pop_front());
      end
      if ((!elem.valid || elem.ready) ) begin
        if (pending_elems.size() > (elem.valid && elem.ready ? 0 : 0) && !src_pause &&
            $urandom_range(99) >= src_idle_pct) begin
          elem.valid <= 1'b1;
          elem.mode  <= pending_elems[0].mode;
          elem.value <= pending_elems[0].value;
          elem.prob  <= pending_elems[0].prob;
        end else begin
          elem.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result idx=%0d prob=%0d grad=%0d last=%0d", $time,
                   result.index, result.probability, result.gradient, result.last);
          fail_count++;
        end else begin
          res_t ex;
          ex = expected_results.pop_front();
          if (ex.index !== result.index || ex.probability !== result.probability ||
              ex.gradient !== result.gradient || ex.last !== result.last) begin
            $display("%0t: mismatch expected idx=%0d prob=%0d grad=%0d last=%0d",
                     $time, ex.index, ex.probability, ex.gradient, ex.last);
            $display("%0t:          actual   idx=%0d prob=%0d grad=%0d last=%0d",
                     $time, result.index, result.probability, result.gradient,
                     result.last);
            fail_count++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog: count cycles with no accepted request on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((elem.valid && elem.ready) || (result.valid && result.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic elem_t mk(logic m, int v, int p);
    elem_t e;
    e.mode = m;
    e.value = v[15:0];
    e.prob = p[15:0];
    return e;
  endfunction

  task automatic drain();
    wait (pending_elems.size() == 0 && !elem.valid);
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_len(int l);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= l[LEN_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    len_reg = l;
    clear_shadow();
  endtask

  task automatic add_random(int n);
    int len;
    logic m;
    len = row_len_eff(len_reg);
    while (n > 0) begin
      m = $urandom_range(1);
      for (int i = 0; i < len && n > 0; i++, n--) begin
        if ($urandom_range(19) == 0) m = ~m;  // broken row: mode switch
        case ($urandom_range(3))
          0: pending_elems.push_back(mk(m, $urandom, $urandom));
          1: pending_elems.push_back(mk(m, $signed($urandom_range(2047)) - 1024,
                                        $urandom_range(65535)));
          default: pending_elems.push_back(mk(m, $signed($urandom_range(511)) - 256,
                                              $urandom_range(65535) >> $urandom_range(4)));
        endcase
      end
    end
  endtask

  initial begin
    elem.valid = 1'b0;
    elem.mode = 1'b0;
    elem.value = '0;
    elem.prob = '0;
    result.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme logits at reset length 16, then extreme gradients at length 4
    for (int i = 0; i < 16; i++)
      pending_elems.push_back(mk(MODE_FWD, (i % 2) ? 32767 : -32768, 0));
    drain();
    set_len(4);
    pending_elems.push_back(mk(MODE_FWD, 100, 0));
    pending_elems.push_back(mk(MODE_BWD, 32767, 65535));   // mode change drops row
    pending_elems.push_back(mk(MODE_BWD, -32768, 65535));
    pending_elems.push_back(mk(MODE_BWD, 32767, 0));
    pending_elems.push_back(mk(MODE_BWD, -32768, 1));
    pending_elems.push_back(mk(MODE_FWD, 5, 0));            // partial row before write
    drain();
    set_len(0);                                             // zero taken as one
    pending_elems.push_back(mk(MODE_FWD, -5, 0));
    pending_elems.push_back(mk(MODE_BWD, -32768, 65535));
    drain();
    set_len(31);                                            // saturates to 16
    add_random(32);

    // receiver holds off while the sender keeps offering
    hold_off = 300;
    drain();
    set_len(3);
    add_random(40);
    drain();
    src_idle_pct = 55;
    snk_idle_pct = 11;
    set_len(16);
    add_random(24);
    drain();
    set_len(1);
    add_random(15);
    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_len(7);
    add_random(35);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
